// File: src/stot_pkg.sv
package stot_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int RADIUS_W    = 15;
  localparam int RR_W        = 2 * RADIUS_W + 1;

  // operand slice width of the pipelined multiplier
  localparam int MUL_CHUNK   = 24;

  // register stages from input capture to the result register
  localparam int PIPE_DEPTH  = 16;

  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPHERE_RADIUS = 4'd0,
    CFG_OFFSET_X      = 4'd1,
    CFG_OFFSET_Y      = 4'd2,
    CFG_OFFSET_Z      = 4'd3
  } cfg_idx_t;

  typedef logic [2:0] sep_t;

  localparam sep_t SEP_NONE    = 3'd0;
  localparam sep_t SEP_PLANE   = 3'd1;
  localparam sep_t SEP_VTX_A   = 3'd2;
  localparam sep_t SEP_VTX_B   = 3'd3;
  localparam sep_t SEP_VTX_C   = 3'd4;
  localparam sep_t SEP_EDGE_AB = 3'd5;
  localparam sep_t SEP_EDGE_BC = 3'd6;
  localparam sep_t SEP_EDGE_CA = 3'd7;

  typedef struct packed {
    logic overlap;
    sep_t sep;
    logic last;
  } res_t;

endpackage

// File: src/stot_if.sv
interface stot_in_if #(parameter int CW = stot_pkg::COORD_WIDTH);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] ax;
  logic signed [CW-1:0] ay;
  logic signed [CW-1:0] az;
  logic signed [CW-1:0] bx;
  logic signed [CW-1:0] by;
  logic signed [CW-1:0] bz;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] cz;
  logic                 last_triangle;

  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_triangle,
                  input ready);
  modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_triangle,
                  output ready);
endinterface

interface stot_out_if;
  logic       valid;
  logic       ready;
  logic       overlap;
  logic [2:0] separated_by;
  logic       last_result;

  modport source (output valid, overlap, separated_by, last_result, input ready);
  modport sink   (input valid, overlap, separated_by, last_result, output ready);
endinterface

interface stot_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [stot_pkg::CFG_IDX_W-1:0]   index;
  logic [stot_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/stot_mul.sv
// Signed multiplier, three register stages: slice products, row sums, final sum.
module stot_mul #(
  parameter int WA = 16,
  parameter int WB = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int C  = stot_pkg::MUL_CHUNK;
  localparam int NA = (WA + C - 1) / C;
  localparam int NB = (WB + C - 1) / C;
  localparam int SW = (NA + NB) * C + 2;
  localparam int PW = 2 * C + 2;

  logic signed [NA*C-1:0] ax;
  logic signed [NB*C-1:0] bx;
  logic signed [C:0]      as [NA];
  logic signed [C:0]      bs [NB];

  logic signed [PW-1:0]   pp_r    [NA][NB];
  logic signed [SW-1:0]   row_nxt [NA];
  logic signed [SW-1:0]   row_r   [NA];
  logic signed [SW-1:0]   p_nxt;
  logic signed [WA+WB-1:0] p_r;

  assign ax = (NA*C)'(a);
  assign bx = (NB*C)'(b);

  // lower slices are unsigned, the top slice carries the sign
  for (genvar i = 0; i < NA; i++) begin : g_as
    if (i == NA - 1) begin : g_top
      assign as[i] = $signed({ax[i*C+C-1], ax[i*C +: C]});
    end else begin : g_low
      assign as[i] = $signed({1'b0, ax[i*C +: C]});
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_bs
    if (j == NB - 1) begin : g_top
      assign bs[j] = $signed({bx[j*C+C-1], bx[j*C +: C]});
    end else begin : g_low
      assign bs[j] = $signed({1'b0, bx[j*C +: C]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= PW'(as[i]) * PW'(bs[j]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (SW'(pp_r[i][j]) <<< (j * C));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r <= row_nxt;
    end
  end

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      p_nxt = p_nxt + (row_r[i] <<< (i * C));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt[WA+WB-1:0];
    end
  end

  assign p = p_r;

endmodule

// File: src/stot_dly.sv
// Alignment delay line that advances with the pipeline.
module stot_dly #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < D; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign q = sh_r[D-1];

endmodule

// File: src/stot_obuf.sv
// Output register plus one spare entry; upstream stalls only when the spare is taken.
module stot_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  stot_pkg::res_t  push_data,
  output logic            en,
  output logic            out_valid,
  input  logic            out_ready,
  output stot_pkg::res_t  out_data
);

  logic           out_vld_r;
  logic           spare_vld_r;
  stot_pkg::res_t out_data_r;
  stot_pkg::res_t spare_r;

  assign en        = !spare_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      spare_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ready) begin
      if (spare_vld_r) begin
        out_vld_r   <= 1'b1;
        spare_vld_r <= 1'b0;
      end else begin
        out_vld_r <= push;
      end
    end else if (push) begin
      spare_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ready) begin
      out_data_r <= spare_vld_r ? spare_r : push_data;
    end else if (push) begin
      spare_r <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_spare_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    spare_vld_r |-> out_vld_r)
    else $error("spare entry held while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    spare_vld_r |-> !push)
    else $error("pipeline pushed into a full output buffer");

  a_stall_fills_spare: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready && push) |=> spare_vld_r)
    else $error("stalled transaction not captured in spare entry");

  a_overlap_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_data_r.overlap == (out_data_r.sep == stot_pkg::SEP_NONE)))
    else $error("overlap flag disagrees with separating axis code");
`endif

endmodule

// File: src/sphere_triangle_overlap_test_top.sv
// Sphere versus triangle overlap test, seven-axis separating test.
// in_if : one triangle per transaction (vertices A, B, C and a last flag).
// out_if: one result per triangle: overlap, separating axis code, last flag.
// cfg_if: register writes, always ready. Index 0 radius, 1..3 offset x/y/z
//         (mesh position minus sphere center). Write only while idle.
// Vertices are shifted by the offset and all products are exact, so the
// result matches a full-precision evaluation bit for bit.
// Pipeline: 16 stages (three chained 3-stage multiplier layers with add and
// compare stages around them); it takes one triangle per cycle while
// in_ready is high.
// Stall: a held result parks in a one-entry spare behind the output
// register; in_ready drops only while that spare is occupied, and then the
// whole pipeline freezes without losing or repeating a transaction.
// Reset (rst_n low, synchronous): all stage valids and the output buffer
// clear, radius and offsets return to zero.
module sphere_triangle_overlap_test_top #(
  parameter int COORD_WIDTH = stot_pkg::COORD_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  stot_in_if.sink    in_if,
  stot_out_if.source out_if,
  stot_cfg_if.sink   cfg_if
);

  localparam int CW     = COORD_WIDTH;
  localparam int PIPE   = stot_pkg::PIPE_DEPTH;
  localparam int RAD_W  = stot_pkg::RADIUS_W;
  localparam int RR_W   = stot_pkg::RR_W;
  localparam int VW     = CW + 1;
  localparam int EW     = CW + 2;
  localparam int NW     = 2 * EW + 1;
  localparam int DW     = 2 * VW + 2;
  localparam int L2W    = 2 * EW + 2;
  localparam int PEW    = VW + EW + 2;
  localparam int DDW    = VW + NW + 2;
  localparam int NNW    = 2 * NW + 2;
  localparam int L2SQW  = 2 * L2W;
  localparam int QW     = VW + L2W + 1;
  localparam int QOW    = QW + 1;
  localparam int QQW    = 2 * QW + 2;
  localparam int QQOW   = QW + QOW + 2;
  localparam int VCW    = (DW > RR_W) ? DW : RR_W;
  localparam int PCW    = (2 * DDW > RR_W + NNW) ? 2 * DDW : RR_W + NNW;
  localparam int ECW    = (QQW > RR_W + L2SQW) ? QQW : RR_W + L2SQW;

  // edge e runs from vertex e to NXT[e]; PRV[e] is the opposite vertex
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};
  // dot pairs: AA, BB, CC, AB, AC, BC
  localparam int PA  [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PB  [6] = '{0, 1, 2, 1, 2, 2};

  logic                     en;
  logic                     push;
  logic [PIPE-1:0]          vld_r;
  stot_pkg::res_t           res;

  // configuration
  logic [RAD_W-1:0]         radius_r;
  logic signed [CW-1:0]     off_r [3];
  logic [2*RAD_W-1:0]       rr_r;
  logic signed [RR_W-1:0]   rrs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      off_r    <= '{default: '0};
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        stot_pkg::CFG_SPHERE_RADIUS: radius_r <= cfg_if.data[RAD_W-1:0];
        stot_pkg::CFG_OFFSET_X:      off_r[0] <= cfg_if.data[CW-1:0];
        stot_pkg::CFG_OFFSET_Y:      off_r[1] <= cfg_if.data[CW-1:0];
        stot_pkg::CFG_OFFSET_Z:      off_r[2] <= cfg_if.data[CW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rr_r <= radius_r * radius_r;
  end

  assign rrs          = $signed({1'b0, rr_r});
  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE-2:0], in_if.valid};
    end
  end

  // stage 1: shift vertices into sphere-centered space
  logic signed [CW-1:0] vin [3][3];
  logic signed [VW-1:0] v_r [3][3];
  logic                 last1_r;

  assign vin[0][0] = in_if.ax;
  assign vin[0][1] = in_if.ay;
  assign vin[0][2] = in_if.az;
  assign vin[1][0] = in_if.bx;
  assign vin[1][1] = in_if.by;
  assign vin[1][2] = in_if.bz;
  assign vin[2][0] = in_if.cx;
  assign vin[2][1] = in_if.cy;
  assign vin[2][2] = in_if.cz;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          v_r[i][k] <= VW'(vin[i][k]) + VW'(off_r[k]);
        end
      end
      last1_r <= in_if.last_triangle;
    end
  end

  // stage 2: edge vectors
  logic signed [VW-1:0] v2_r [3][3];
  logic signed [EW-1:0] e_r  [3][3];
  logic signed [EW-1:0] ac_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      v2_r <= v_r;
      for (int e = 0; e < 3; e++) begin
        for (int k = 0; k < 3; k++) begin
          e_r[e][k] <= EW'(v_r[NXT[e]][k]) - EW'(v_r[e][k]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        ac_r[k] <= EW'(v_r[2][k]) - EW'(v_r[0][k]);
      end
    end
  end

  // stages 3-5: first multiplier layer
  logic signed [2*EW-1:0]  cp_w [3][2];
  logic signed [2*VW-1:0]  vv_w [6][3];
  logic signed [2*EW-1:0]  ll_w [3][3];
  logic signed [VW+EW-1:0] pe_w [3][3];

  for (genvar k = 0; k < 3; k++) begin : g_cross
    stot_mul #(.WA(EW), .WB(EW)) u_cp0 (
      .clk(clk), .en(en), .a(e_r[0][NXT[k]]), .b(ac_r[PRV[k]]), .p(cp_w[k][0]));
    stot_mul #(.WA(EW), .WB(EW)) u_cp1 (
      .clk(clk), .en(en), .a(e_r[0][PRV[k]]), .b(ac_r[NXT[k]]), .p(cp_w[k][1]));
  end

  for (genvar m = 0; m < 6; m++) begin : g_vv
    for (genvar k = 0; k < 3; k++) begin : g_k
      stot_mul #(.WA(VW), .WB(VW)) u_vv (
        .clk(clk), .en(en), .a(v2_r[PA[m]][k]), .b(v2_r[PB[m]][k]), .p(vv_w[m][k]));
    end
  end

  for (genvar e = 0; e < 3; e++) begin : g_edge1
    for (genvar k = 0; k < 3; k++) begin : g_k
      stot_mul #(.WA(EW), .WB(EW)) u_ll (
        .clk(clk), .en(en), .a(e_r[e][k]), .b(e_r[e][k]), .p(ll_w[e][k]));
      stot_mul #(.WA(VW), .WB(EW)) u_pe (
        .clk(clk), .en(en), .a(v2_r[e][k]), .b(e_r[e][k]), .p(pe_w[e][k]));
    end
  end

  // stage 6: normal, dot products, edge lengths, projections
  logic signed [NW-1:0]  n_r    [3];
  logic signed [DW-1:0]  dot_r  [6];
  logic signed [L2W-1:0] len2_r [3];
  logic signed [PEW-1:0] pe_r   [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n_r[k] <= NW'(cp_w[k][0]) - NW'(cp_w[k][1]);
      end
      for (int m = 0; m < 6; m++) begin
        dot_r[m] <= DW'(vv_w[m][0]) + DW'(vv_w[m][1]) + DW'(vv_w[m][2]);
      end
      for (int e = 0; e < 3; e++) begin
        len2_r[e] <= L2W'(ll_w[e][0]) + L2W'(ll_w[e][1]) + L2W'(ll_w[e][2]);
        pe_r[e]   <= PEW'(pe_w[e][0]) + PEW'(pe_w[e][1]) + PEW'(pe_w[e][2]);
      end
    end
  end

  // vertices and edges realigned to stage 6
  logic signed [VW-1:0] v6_w [3][3];
  logic signed [EW-1:0] e6_w [3][3];

  for (genvar i = 0; i < 3; i++) begin : g_dly6
    for (genvar k = 0; k < 3; k++) begin : g_k
      stot_dly #(.W(VW), .D(4)) u_v6 (
        .clk(clk), .en(en), .d(v2_r[i][k]), .q(v6_w[i][k]));
      stot_dly #(.W(EW), .D(4)) u_e6 (
        .clk(clk), .en(en), .d(e_r[i][k]), .q(e6_w[i][k]));
    end
  end

  // stage 7: vertex separation, lowest vertex in bit 0
  logic [2:0] vtx_r;
  logic [2:0] vtx16_w;

  always_ff @(posedge clk) begin
    if (en) begin
      vtx_r[0] <= (VCW'(dot_r[0]) > VCW'(rrs)) && (dot_r[3] > dot_r[0]) &&
                  (dot_r[4] > dot_r[0]);
      vtx_r[1] <= (VCW'(dot_r[1]) > VCW'(rrs)) && (dot_r[3] > dot_r[1]) &&
                  (dot_r[5] > dot_r[1]);
      vtx_r[2] <= (VCW'(dot_r[2]) > VCW'(rrs)) && (dot_r[4] > dot_r[2]) &&
                  (dot_r[5] > dot_r[2]);
    end
  end

  stot_dly #(.W(3), .D(PIPE - 7)) u_vtx16 (
    .clk(clk), .en(en), .d(vtx_r), .q(vtx16_w));

  // stages 7-9: second multiplier layer
  logic signed [VW+NW-1:0]  dp_w  [3];
  logic signed [2*NW-1:0]   np_w  [3];
  logic signed [L2SQW-1:0]  lsq_w [3];
  logic signed [VW+L2W-1:0] pl_w  [3][3];
  logic signed [EW+PEW-1:0] ep_w  [3][3];
  logic signed [VW+L2W-1:0] ol_w  [3][3];

  for (genvar k = 0; k < 3; k++) begin : g_plane2
    stot_mul #(.WA(VW), .WB(NW)) u_dp (
      .clk(clk), .en(en), .a(v6_w[0][k]), .b(n_r[k]), .p(dp_w[k]));
    stot_mul #(.WA(NW), .WB(NW)) u_np (
      .clk(clk), .en(en), .a(n_r[k]), .b(n_r[k]), .p(np_w[k]));
  end

  for (genvar e = 0; e < 3; e++) begin : g_edge2
    stot_mul #(.WA(L2W), .WB(L2W)) u_lsq (
      .clk(clk), .en(en), .a(len2_r[e]), .b(len2_r[e]), .p(lsq_w[e]));
    for (genvar k = 0; k < 3; k++) begin : g_k
      stot_mul #(.WA(VW), .WB(L2W)) u_pl (
        .clk(clk), .en(en), .a(v6_w[e][k]), .b(len2_r[e]), .p(pl_w[e][k]));
      stot_mul #(.WA(EW), .WB(PEW)) u_ep (
        .clk(clk), .en(en), .a(e6_w[e][k]), .b(pe_r[e]), .p(ep_w[e][k]));
      stot_mul #(.WA(VW), .WB(L2W)) u_ol (
        .clk(clk), .en(en), .a(v6_w[PRV[e]][k]), .b(len2_r[e]), .p(ol_w[e][k]));
    end
  end

  // stage 10: plane distance, normal length, closest-point numerators
  logic signed [DDW-1:0]    d_r;
  logic signed [NNW-1:0]    nn_r;
  logic signed [QW-1:0]     q_r  [3][3];
  logic signed [VW+L2W-1:0] ol_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r  <= DDW'(dp_w[0]) + DDW'(dp_w[1]) + DDW'(dp_w[2]);
      nn_r <= NNW'(np_w[0]) + NNW'(np_w[1]) + NNW'(np_w[2]);
      for (int e = 0; e < 3; e++) begin
        for (int k = 0; k < 3; k++) begin
          q_r[e][k]  <= QW'(pl_w[e][k]) - QW'(ep_w[e][k]);
          ol_r[e][k] <= ol_w[e][k];
        end
      end
    end
  end

  // stage 11: opposite-vertex direction
  logic signed [DDW-1:0]   d11_r;
  logic signed [NNW-1:0]   nn11_r;
  logic signed [QW-1:0]    q11_r [3][3];
  logic signed [QOW-1:0]   qo_r  [3][3];
  logic signed [L2SQW-1:0] lsq11_w [3];

  always_ff @(posedge clk) begin
    if (en) begin
      d11_r  <= d_r;
      nn11_r <= nn_r;
      q11_r  <= q_r;
      for (int e = 0; e < 3; e++) begin
        for (int k = 0; k < 3; k++) begin
          qo_r[e][k] <= QOW'(ol_r[e][k]) - QOW'(q_r[e][k]);
        end
      end
    end
  end

  for (genvar e = 0; e < 3; e++) begin : g_lsq11
    stot_dly #(.W(L2SQW), .D(2)) u_lsq11 (
      .clk(clk), .en(en), .d(lsq_w[e]), .q(lsq11_w[e]));
  end

  // stages 12-14: third multiplier layer
  logic signed [2*DDW-1:0]      dd_w;
  logic signed [RR_W+NNW-1:0]   rnn_w;
  logic signed [RR_W+L2SQW-1:0] rl_w  [3];
  logic signed [2*QW-1:0]       qq_w  [3][3];
  logic signed [QW+QOW-1:0]     qqo_w [3][3];

  stot_mul #(.WA(DDW), .WB(DDW)) u_dd (
    .clk(clk), .en(en), .a(d11_r), .b(d11_r), .p(dd_w));
  stot_mul #(.WA(RR_W), .WB(NNW)) u_rnn (
    .clk(clk), .en(en), .a(rrs), .b(nn11_r), .p(rnn_w));

  for (genvar e = 0; e < 3; e++) begin : g_edge3
    stot_mul #(.WA(RR_W), .WB(L2SQW)) u_rl (
      .clk(clk), .en(en), .a(rrs), .b(lsq11_w[e]), .p(rl_w[e]));
    for (genvar k = 0; k < 3; k++) begin : g_k
      stot_mul #(.WA(QW), .WB(QW)) u_qq (
        .clk(clk), .en(en), .a(q11_r[e][k]), .b(q11_r[e][k]), .p(qq_w[e][k]));
      stot_mul #(.WA(QW), .WB(QOW)) u_qqo (
        .clk(clk), .en(en), .a(q11_r[e][k]), .b(qo_r[e][k]), .p(qqo_w[e][k]));
    end
  end

  // stage 15: edge sums
  logic signed [2*DDW-1:0]      dd_r;
  logic signed [RR_W+NNW-1:0]   rnn_r;
  logic signed [RR_W+L2SQW-1:0] rl_r  [3];
  logic signed [QQW-1:0]        qq_r  [3];
  logic signed [QQOW-1:0]       qqo_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      dd_r  <= dd_w;
      rnn_r <= rnn_w;
      rl_r  <= rl_w;
      for (int e = 0; e < 3; e++) begin
        qq_r[e]  <= QQW'(qq_w[e][0]) + QQW'(qq_w[e][1]) + QQW'(qq_w[e][2]);
        qqo_r[e] <= QQOW'(qqo_w[e][0]) + QQOW'(qqo_w[e][1]) + QQOW'(qqo_w[e][2]);
      end
    end
  end

  // stage 16: plane and edge separation flags
  logic       plane_r;
  logic [2:0] edge_r;
  logic       last16_w;

  always_ff @(posedge clk) begin
    if (en) begin
      plane_r <= PCW'(dd_r) > PCW'(rnn_r);
      for (int e = 0; e < 3; e++) begin
        edge_r[e] <= (ECW'(qq_r[e]) > ECW'(rl_r[e])) &&
                     !qqo_r[e][QQOW-1] && (qqo_r[e] != '0);
      end
    end
  end

  stot_dly #(.W(1), .D(PIPE - 1)) u_last16 (
    .clk(clk), .en(en), .d(last1_r), .q(last16_w));

  // first separating axis in test order wins
  always_comb begin
    res.last = last16_w;
    if (plane_r) begin
      res.sep = stot_pkg::SEP_PLANE;
    end else if (vtx16_w[0]) begin
      res.sep = stot_pkg::SEP_VTX_A;
    end else if (vtx16_w[1]) begin
      res.sep = stot_pkg::SEP_VTX_B;
    end else if (vtx16_w[2]) begin
      res.sep = stot_pkg::SEP_VTX_C;
    end else if (edge_r[0]) begin
      res.sep = stot_pkg::SEP_EDGE_AB;
    end else if (edge_r[1]) begin
      res.sep = stot_pkg::SEP_EDGE_BC;
    end else if (edge_r[2]) begin
      res.sep = stot_pkg::SEP_EDGE_CA;
    end else begin
      res.sep = stot_pkg::SEP_NONE;
    end
    res.overlap = (res.sep == stot_pkg::SEP_NONE);
  end

  assign push = en && vld_r[PIPE-1];

  stot_pkg::res_t out_data;

  stot_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .en        (en),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_data)
  );

  assign out_if.overlap      = out_data.overlap;
  assign out_if.separated_by = out_data.sep;
  assign out_if.last_result  = out_data.last;

endmodule
